// ===== rtl/tach_pkg.sv =====
// Shared types, constants and codes for the tachometer rpm block.
package tach_pkg;

    localparam int unsigned PprWidth    = 4;
    localparam int unsigned ThrWidth    = 16;
    localparam int unsigned TimeWidth   = 32;
    localparam int unsigned RpmWidth    = 16;
    localparam int unsigned StatusWidth = 2;
    localparam int unsigned CfgWidth    = 16;
    localparam int unsigned DivWidth    = 32;
    localparam int unsigned ProdWidth   = DivWidth + PprWidth;

    localparam logic [DivWidth-1:0] RPM_NUMERATOR = 32'd60000000;
    localparam logic [RpmWidth-1:0] RPM_MAX       = 16'hFFFF;
    localparam logic [PprWidth-1:0] PPR_RESET     = 4'd3;
    localparam logic [ThrWidth-1:0] FAST_RESET    = 16'd1500;

    localparam logic [StatusWidth-1:0] STATUS_OK       = 2'd0;
    localparam logic [StatusWidth-1:0] STATUS_NO_PULSE = 2'd1;
    localparam logic [StatusWidth-1:0] STATUS_NO_NEW   = 2'd2;

    localparam logic CMD_PULSE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic CFG_PPR  = 1'b0;
    localparam logic CFG_FAST = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [TimeWidth-1:0] time_us;
    } tach_in_t;

    typedef struct packed {
        logic [RpmWidth-1:0]    rpm;
        logic [StatusWidth-1:0] status;
        logic                   fast_update;
    } tach_out_t;

    typedef struct packed {
        logic                start;
        logic [DivWidth-1:0] dividend;
        logic [DivWidth-1:0] divisor;
    } tach_div_req_t;

    typedef struct packed {
        logic                done;
        logic [DivWidth-1:0] quotient;
    } tach_div_rsp_t;

endpackage

// ===== rtl/tachometer_pulse_rate_to_rpm_top.sv =====
// Tachometer rpm block: pulse bookkeeping, read sequencer and result register.
//
// A pulse beat is taken in S_IDLE, which it does not leave, so pulse beats can follow back
// to back. A read beat goes through these steps before the next beat is accepted:
// - one pass of the shared divider for microseconds per pulse;
// - S_DIV1 takes that quotient and multiplies it by pulses_per_rev;
// - S_MUL checks the product;
// - a second pass for 60000000 over the product;
// - S_DIV2 takes the quotient, and S_EMIT loads the result register.
// A read with no pulses ever seen, or with no new pulses, goes straight to S_EMIT. A
// zero period, or a product beyond 32 bits, ends after the first pass. in_stall stays
// high while a read is in flight. A finished read holds until the output register is
// free, so a stalled result adds its stall cycles to the read. Once the result is
// loaded, the next beat is taken while that result still waits downstream.
module tachometer_pulse_rate_to_rpm_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tach_pkg::tach_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tach_pkg::tach_out_t  out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [tach_pkg::CfgWidth-1:0] cfg_data
);

    localparam int unsigned TW = tach_pkg::TimeWidth;
    localparam int unsigned DW = tach_pkg::DivWidth;
    localparam int unsigned PW = tach_pkg::ProdWidth;
    localparam int unsigned RW = tach_pkg::RpmWidth;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [tach_pkg::PprWidth-1:0] ppr_reg, ppr_next;
    logic [tach_pkg::ThrWidth-1:0] thr_reg, thr_next;

    logic [TW-1:0] pc_reg, pc_next;
    logic [TW-1:0] lpt_reg, lpt_next;
    logic [TW-1:0] prc_reg, prc_next;
    logic [TW-1:0] prt_reg, prt_next;

    logic [PW-1:0] prod_reg, prod_next;
    logic [RW-1:0] rpm_reg, rpm_next;
    logic [tach_pkg::StatusWidth-1:0] st_reg, st_next;

    logic                out_valid_reg, out_valid_next;
    tach_pkg::tach_out_t out_reg, out_next;

    logic [TW-1:0] dcount;
    logic [TW-1:0] dtime;
    logic          in_acc;
    logic          out_free;

    tach_pkg::tach_div_req_t div_req;
    tach_pkg::tach_div_rsp_t div_rsp;

    tach_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign dcount   = pc_reg - prc_reg;
    assign dtime    = lpt_reg - prt_reg;

    always_comb
    begin
        state_next     = state_reg;
        ppr_next       = ppr_reg;
        thr_next       = thr_reg;
        pc_next        = pc_reg;
        lpt_next       = lpt_reg;
        prc_next       = prc_reg;
        prt_next       = prt_reg;
        prod_next      = prod_reg;
        rpm_next       = rpm_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        div_req.start    = 1'b0;
        div_req.dividend = dtime;
        div_req.divisor  = dcount;

        if (cfg_we)
        begin
            case (cfg_index)
                tach_pkg::CFG_PPR:  ppr_next = cfg_data[tach_pkg::PprWidth-1:0];
                tach_pkg::CFG_FAST: thr_next = cfg_data[tach_pkg::ThrWidth-1:0];
                default:            ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_data.cmd == tach_pkg::CMD_PULSE)
                    begin
                        pc_next  = pc_reg + 1'b1;
                        lpt_next = in_data.time_us;
                    end
                    else if (pc_reg == '0)
                    begin
                        rpm_next   = '0;
                        st_next    = tach_pkg::STATUS_NO_PULSE;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        prc_next = pc_reg;
                        prt_next = lpt_reg;
                        if (dcount == '0)
                        begin
                            rpm_next   = '0;
                            st_next    = tach_pkg::STATUS_NO_NEW;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV1;
                        end
                    end
                end
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    prod_next  = PW'(div_rsp.quotient) * PW'(ppr_reg);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                div_req.dividend = tach_pkg::RPM_NUMERATOR;
                div_req.divisor  = prod_reg[DW-1:0];
                if (prod_reg == '0)
                begin
                    rpm_next   = '0;
                    st_next    = tach_pkg::STATUS_NO_NEW;
                    state_next = S_EMIT;
                end
                else if (prod_reg[PW-1:DW] != '0)
                begin
                    rpm_next   = '0;
                    st_next    = tach_pkg::STATUS_OK;
                    state_next = S_EMIT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient[DW-1:RW] != '0)
                    begin
                        rpm_next = tach_pkg::RPM_MAX;
                    end
                    else
                    begin
                        rpm_next = div_rsp.quotient[RW-1:0];
                    end
                    st_next    = tach_pkg::STATUS_OK;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next.rpm         = rpm_reg;
                    out_next.status      = st_reg;
                    out_next.fast_update = (rpm_reg >= thr_reg);
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ppr_reg       <= tach_pkg::PPR_RESET;
            thr_reg       <= tach_pkg::FAST_RESET;
            pc_reg        <= '0;
            lpt_reg       <= '0;
            prc_reg       <= '0;
            prt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ppr_reg       <= ppr_next;
            thr_reg       <= thr_next;
            pc_reg        <= pc_next;
            lpt_reg       <= lpt_next;
            prc_reg       <= prc_next;
            prt_reg       <= prt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rpm_reg  <= rpm_next;
        st_reg   <= st_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV1 || state_reg == S_DIV2)
        else $error("divider finished outside a wait state");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.status != 2'd3)
        else $error("unknown status on result");

    a_error_rpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != tach_pkg::STATUS_OK |-> out_reg.rpm == '0)
        else $error("nonzero rpm with error status");

endmodule

// ===== rtl/tach_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module tach_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tach_pkg::tach_div_req_t req,
    output tach_pkg::tach_div_rsp_t rsp
);

    localparam int unsigned W  = tach_pkg::DivWidth;
    localparam int unsigned CW = $clog2(W);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = CW'(W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

    a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> dvs_reg != '0)
        else $error("divider running on a zero divisor");

endmodule

// ===== verif/tachometer_pulse_rate_to_rpm_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the tachometer rpm block: pulse and read beats against a predictor.
module tachometer_pulse_rate_to_rpm_top_test;

    localparam int unsigned StallLimit  = 2000;
    localparam int unsigned DrainCycles = 100;
    localparam int unsigned HoldCycles  = 400;
    localparam int unsigned ReportLimit = 10;

    localparam int unsigned TW = tach_pkg::TimeWidth;
    localparam int unsigned DW = tach_pkg::DivWidth;
    localparam int unsigned PW = tach_pkg::ProdWidth;
    localparam int unsigned RW = tach_pkg::RpmWidth;
    localparam int unsigned NW = tach_pkg::PprWidth;
    localparam int unsigned HW = tach_pkg::ThrWidth;
    localparam int unsigned CW = tach_pkg::CfgWidth;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    tach_pkg::tach_in_t  in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    tach_pkg::tach_out_t out_data;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = tach_pkg::CFG_PPR;
    logic [CW-1:0]       cfg_data  = '0;

    logic [NW-1:0] ppr_q           = tach_pkg::PPR_RESET;
    logic [HW-1:0] thr_q           = tach_pkg::FAST_RESET;
    logic [TW-1:0] pulse_count     = '0;
    logic [TW-1:0] last_pulse_time = '0;
    logic [TW-1:0] prev_read_count = '0;
    logic [TW-1:0] prev_read_time  = '0;
    logic [TW-1:0] next_pulse_time = '0;

    tach_pkg::tach_in_t  pending_beats[$];
    tach_pkg::tach_out_t expected_readings[$];

    int   beats_queued   = 0;
    int   beats_taken    = 0;
    int   pulses_taken   = 0;
    int   readings_seen  = 0;
    int   mismatches     = 0;
    int   stray_readings = 0;
    int   status_hits[4] = '{0, 0, 0, 0};
    int   fast_hits      = 0;
    int   sat_hits       = 0;
    int   in_gap_max     = 3;
    int   out_gap_max    = 3;
    int   in_gap_left    = 0;
    int   stall_left     = 0;
    int   hold_left      = 0;
    int   hold_request   = 0;
    int   hold_served    = 0;
    int   idle_cycles    = 0;
    logic in_taken       = 1'b0;
    logic out_taken      = 1'b0;

    tachometer_pulse_rate_to_rpm_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic tach_pkg::tach_out_t rpm_from_deltas(input logic [TW-1:0] dtime,
                                                            input logic [TW-1:0] dcount);
        tach_pkg::tach_out_t r;
        logic [DW-1:0]       per_pulse;
        logic [PW-1:0]       period_rev;
        logic [PW-1:0]       quotient;
        r        = '0;
        r.status = tach_pkg::STATUS_NO_NEW;
        if (dcount != '0)
        begin
            per_pulse  = dtime / dcount;
            period_rev = {{NW{1'b0}}, per_pulse} * {{DW{1'b0}}, ppr_q};
            if (period_rev != '0)
            begin
                quotient = {{NW{1'b0}}, tach_pkg::RPM_NUMERATOR} / period_rev;
                r.status = tach_pkg::STATUS_OK;
                if (quotient[PW-1:RW] != '0)
                    r.rpm = tach_pkg::RPM_MAX;
                else
                    r.rpm = quotient[RW-1:0];
            end
        end
        r.fast_update = (r.rpm >= thr_q);
        return r;
    endfunction

    task automatic track_beat(input tach_pkg::tach_in_t beat);
        tach_pkg::tach_out_t r;
        if (beat.cmd == tach_pkg::CMD_PULSE)
        begin
            pulse_count     = pulse_count + 1'b1;
            last_pulse_time = beat.time_us;
            pulses_taken++;
        end
        else
        begin
            if (pulse_count == '0)
            begin
                r             = '0;
                r.status      = tach_pkg::STATUS_NO_PULSE;
                r.fast_update = (thr_q == '0);
            end
            else
            begin
                r = rpm_from_deltas(last_pulse_time - prev_read_time,
                                    pulse_count - prev_read_count);
                prev_read_count = pulse_count;
                prev_read_time  = last_pulse_time;
            end
            status_hits[r.status]++;
            if (r.fast_update)
                fast_hits++;
            if (r.status == tach_pkg::STATUS_OK && r.rpm == tach_pkg::RPM_MAX)
                sat_hits++;
            expected_readings.push_back(r);
        end
    endtask

    always @(posedge clk)
    begin : watch_beats
        tach_pkg::tach_out_t want;
        logic                busy;
        in_taken  <= in_valid && !in_stall;
        out_taken <= out_valid && !out_stall;
        if (rst_n)
        begin
            busy = 1'b0;
            if (in_valid && !in_stall)
            begin
                track_beat(in_data);
                beats_taken++;
                busy = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                busy = 1'b1;
                readings_seen++;
                if (expected_readings.size() == 0)
                begin
                    stray_readings++;
                    if (mismatches + stray_readings <= ReportLimit)
                        $display("unexpected reading: rpm %0d status %0d fast %0d",
                                 out_data.rpm, out_data.status, out_data.fast_update);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (out_data.rpm !== want.rpm || out_data.status !== want.status ||
                        out_data.fast_update !== want.fast_update)
                    begin
                        mismatches++;
                        if (mismatches + stray_readings <= ReportLimit)
                            $display({"reading %0d: expected rpm %0d status %0d fast %0d,",
                                      " got rpm %0d status %0d fast %0d"},
                                     readings_seen, want.rpm, want.status,
                                     want.fast_update, out_data.rpm, out_data.status,
                                     out_data.fast_update);
                    end
                end
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= StallLimit)
            begin
                $display("no beat moved for %0d cycles", StallLimit);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin : drive_in
        logic               next_valid;
        tach_pkg::tach_in_t next_data;
        next_valid = in_valid && !in_taken;
        next_data  = in_data;
        if (!next_valid)
        begin
            if (in_gap_left > 0)
                in_gap_left--;
            else if (pending_beats.size() > 0)
            begin
                next_data   = pending_beats.pop_front();
                next_valid  = 1'b1;
                in_gap_left = $urandom_range(0, in_gap_max);
            end
        end
        in_valid <= next_valid;
        in_data  <= next_data;
    end

    always @(negedge clk)
    begin
        if (hold_request != hold_served)
        begin
            hold_served = hold_request;
            hold_left   = HoldCycles;
        end
        if (out_taken)
            stall_left = $urandom_range(0, out_gap_max);
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic queue_beat(input logic cmd, input logic [TW-1:0] t);
        tach_pkg::tach_in_t beat;
        beat.cmd     = cmd;
        beat.time_us = t;
        pending_beats.push_back(beat);
        beats_queued++;
        if (cmd == tach_pkg::CMD_PULSE)
            next_pulse_time = t;
    endtask

    task automatic queue_random_beats(input int n);
        int            count;
        int            kind;
        int            k;
        logic [TW-1:0] lo;
        logic [TW-1:0] hi;
        count = 0;
        while (count < n)
        begin
            kind = $urandom_range(0, 19);
            k    = $urandom_range(1, 6);
            if (kind < 15)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        lo = 1;
                        hi = 40;
                    end
                    1:
                    begin
                        lo = 200;
                        hi = 6000;
                    end
                    2:
                    begin
                        lo = 6000;
                        hi = 300000;
                    end
                    default:
                    begin
                        lo = 0;
                        hi = 32'hFFFF_FFFF;
                    end
                endcase
                repeat (k)
                    queue_beat(tach_pkg::CMD_PULSE, next_pulse_time + $urandom_range(hi, lo));
                queue_beat(tach_pkg::CMD_READ, $urandom);
                count += k + 1;
            end
            else if (kind < 17)
            begin
                // repeat the last timestamp so the period collapses
                repeat (k)
                    queue_beat(tach_pkg::CMD_PULSE, next_pulse_time);
                queue_beat(tach_pkg::CMD_READ, $urandom);
                count += k + 1;
            end
            else if (kind == 17)
            begin
                queue_beat(tach_pkg::CMD_READ, $urandom);
                count++;
            end
            else
            begin
                queue_beat(logic'($urandom_range(0, 1)), $urandom);
                count++;
            end
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (beats_taken != beats_queued || expected_readings.size() != 0);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == tach_pkg::CFG_PPR)
            ppr_q = value[NW-1:0];
        else
            thr_q = value[HW-1:0];
    endtask

    task automatic start_phase(input logic [CW-1:0] ppr_word,
                               input logic [CW-1:0] thr_word,
                               input int in_gap, input int out_gap);
        settle();
        write_reg(tach_pkg::CFG_PPR, ppr_word);
        write_reg(tach_pkg::CFG_FAST, thr_word);
        @(posedge clk);
        in_gap_max  = in_gap;
        out_gap_max = out_gap;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_beat(tach_pkg::CMD_READ,  32'h0000_0000);
        queue_beat(tach_pkg::CMD_PULSE, 32'h0000_0000);
        queue_beat(tach_pkg::CMD_READ,  32'hFFFF_FFFF);
        queue_beat(tach_pkg::CMD_READ,  32'h0000_0000);
        queue_beat(tach_pkg::CMD_PULSE, 32'd1000);
        queue_beat(tach_pkg::CMD_PULSE, 32'd2000);
        queue_beat(tach_pkg::CMD_PULSE, 32'd3000);
        queue_beat(tach_pkg::CMD_READ,  32'h5A5A_A5A5);
        queue_beat(tach_pkg::CMD_PULSE, 32'hFFFF_FF00);
        queue_beat(tach_pkg::CMD_PULSE, 32'h0000_0100);
        queue_beat(tach_pkg::CMD_READ,  32'hA5A5_5A5A);
        queue_beat(tach_pkg::CMD_PULSE, 32'h0000_0101);
        queue_beat(tach_pkg::CMD_PULSE, 32'h0000_0102);
        queue_beat(tach_pkg::CMD_READ,  32'h0000_0000);
        queue_beat(tach_pkg::CMD_PULSE, 32'hFFFF_FFFF);
        queue_beat(tach_pkg::CMD_READ,  32'hFFFF_FFFF);
        queue_beat(tach_pkg::CMD_PULSE, 32'hFFFF_FFFF + 32'd20000);
        queue_beat(tach_pkg::CMD_READ,  32'h1234_5678);
        queue_beat(tach_pkg::CMD_PULSE, next_pulse_time + 32'd13333);
        queue_beat(tach_pkg::CMD_READ,  32'h8765_4321);
        queue_beat(tach_pkg::CMD_PULSE, next_pulse_time + 32'd13334);
        queue_beat(tach_pkg::CMD_READ,  32'h0000_0001);
        queue_beat(tach_pkg::CMD_PULSE, next_pulse_time);
        queue_beat(tach_pkg::CMD_READ,  32'h8000_0000);

        start_phase(16'd1, 16'd0, 0, 0);
        queue_random_beats(130);

        start_phase(16'hFFFF, 16'hFFFF, 3, 3);
        queue_random_beats(130);
        @(posedge clk);
        hold_request++;

        start_phase({12'($urandom), 4'd0}, 16'($urandom), 3, 3);
        queue_random_beats(40);

        start_phase({12'($urandom), 4'($urandom_range(1, 15))},
                    16'($urandom_range(500, 20000)), 3, 1);
        queue_random_beats(170);

        start_phase({12'($urandom), 4'($urandom_range(1, 15))},
                    16'($urandom_range(0, 65535)), 1, 3);
        queue_random_beats(170);

        settle();
        $display("ran %0d beats (%0d pulses), checked %0d readings:",
                 beats_taken, pulses_taken, readings_seen);
        $display("  %0d ok, %0d no-pulse, %0d no-new, %0d saturated, %0d fast-update",
                 status_hits[tach_pkg::STATUS_OK], status_hits[tach_pkg::STATUS_NO_PULSE],
                 status_hits[tach_pkg::STATUS_NO_NEW], sat_hits, fast_hits);
        $display("mismatches %0d, stray %0d", mismatches, stray_readings);
        if (mismatches == 0 && stray_readings == 0 && expected_readings.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== tachometer_pulse_rate_to_rpm_top.f =====
rtl/tach_pkg.sv
rtl/tach_divider.sv
rtl/tachometer_pulse_rate_to_rpm_top.sv
verif/tachometer_pulse_rate_to_rpm_top_test.sv
